/* hdl/sas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants of the sieve accumulate and scan block
// Field types, operation codes and the threshold reset value.
// ----------------------------------------------------------------------------
package sas_pkg;

    // Field types, as carried on the request and result channels
    typedef logic [1:0]  t_op;
    typedef logic [23:0] t_prime;
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_index;

    // Operation codes; code 3 is unused and only returns an empty result
    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_ADD   = 2'd1;
    localparam t_op OP_FIND  = 2'd2;

    // Sieve position width: a root plus one stride of the largest prime
    localparam int POS_W = 25;

    localparam t_byte THRESHOLD_RESET = 8'd38;

endpackage

/* hdl/sas_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_if: request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface sas_req_if import sas_pkg::*; ();
    logic   valid;
    logic   ready;
    t_op    operation;
    t_prime prime;
    t_prime root_one;
    t_prime root_two;
    logic   root_two_valid;
    t_byte  log_weight;
    t_index start_index;

    modport source (
        output valid, operation, prime, root_one, root_two, root_two_valid,
               log_weight, start_index,
        input  ready
    );
    modport sink (
        input  valid, operation, prime, root_one, root_two, root_two_valid,
               log_weight, start_index,
        output ready
    );
endinterface

interface sas_res_if import sas_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   found;
    t_index index;
    t_byte  value;

    modport source (output valid, found, index, value, input ready);
    modport sink   (input valid, found, index, value, output ready);
endinterface

/* hdl/sieve_accumulate_and_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_accumulate_and_scan: logarithmic sieve store with accumulate and scan
// Byte counters in one synchronous memory, cleared, accumulated per prime
// and scanned for the first counter above a threshold.
// ----------------------------------------------------------------------------
// The block keeps SIEVE_BYTES byte counters in a single simple dual-port
// memory (one write port, one read port, registered read data) and serves
// one request at a time; every request returns exactly one result. After
// reset a clearing pass writes zero to every entry, during which no request
// is taken (the threshold register can still be written). A clear request
// runs the same pass. An add request walks each root r in steps of the
// prime with a pipelined read-modify-write, one counter per cycle, over the
// positions r + k*prime below SIEVE_BYTES; an add with the second root
// marked invalid, or with a zero prime, writes nothing. A find request reads
// one counter per cycle from the start index and stops at the first counter
// above the threshold or at the end of the store. The result sits in an
// output register, so the next request is taken while a result still waits
// to be collected; a further result waits until that register is free.
// ----------------------------------------------------------------------------
module sieve_accumulate_and_scan import sas_pkg::*; #(
    parameter int SIEVE_BYTES = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  t_byte         i_cfg_wr_data,
    sas_req_if.sink       i_req,
    sas_res_if.source     o_res
);

    localparam int AW = $clog2(SIEVE_BYTES);
    localparam logic [POS_W-1:0] LIMIT = POS_W'(SIEVE_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_FIND,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [POS_W-1:0] r_pos;       // sweep / stride / scan position
    logic [POS_W-1:0] r_addr;      // position whose read data is in flight
    logic             r_pend;      // read data in flight for r_addr
    logic             r_second;    // walking the second root
    logic             r_is_op;     // clear pass belongs to a request
    t_prime           r_prime;
    t_prime           r_root_two;
    t_byte            r_weight;
    t_byte            r_threshold;

    logic             r_res_found;
    t_index           r_res_index;
    t_byte            r_res_value;

    logic             r_out_valid;
    logic             r_out_found;
    t_index           r_out_index;
    t_byte            r_out_value;
    logic             out_load;

    // Counter memory
    t_byte            r_mem [SIEVE_BYTES];
    t_byte            r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_byte            mem_wdata;
    logic             pos_in_range;
    logic             hit;

    assign pos_in_range = (r_pos < LIMIT);
    assign hit          = r_pend && (r_rdata > r_threshold);
    // Move the finished result into the output register once it is free
    assign out_load     = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // Clearing pass writes zero at the sweep position; an add writes back
    // the counter read in the cycle before plus the weight. Within a stride
    // walk successive addresses differ, and the turn-around between the two
    // roots lets the last write land before the second walk reads.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pos[AW-1:0];
        mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_ADD && r_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr[AW-1:0];
            mem_wdata = r_rdata + r_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_pos[AW-1:0]];
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_second    <= 1'b0;
            r_is_op     <= 1'b0;
            r_out_valid <= 1'b0;
            r_threshold <= THRESHOLD_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
            // Refill the output register from S_DONE, else drop the result
            // once collected
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_is_op     <= 1'b1;
                        r_pend      <= 1'b0;
                        r_second    <= 1'b0;
                        r_res_found <= 1'b0;
                        r_res_index <= '0;
                        r_res_value <= '0;
                        r_prime     <= i_req.prime;
                        r_root_two  <= i_req.root_two;
                        r_weight    <= i_req.log_weight;
                        case (i_req.operation)
                            OP_CLEAR: begin
                                r_pos   <= '0;
                                r_state <= S_CLEAR;
                            end
                            OP_ADD: begin
                                if (i_req.root_two_valid && (i_req.prime != '0)) begin
                                    r_pos   <= POS_W'(i_req.root_one);
                                    r_state <= S_ADD;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            OP_FIND: begin
                                r_pos   <= POS_W'(i_req.start_index);
                                r_state <= S_FIND;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_CLEAR: begin
                    r_pos <= r_pos + POS_W'(1);
                    if (r_pos == LIMIT - POS_W'(1)) begin
                        r_state <= r_is_op ? S_DONE : S_IDLE;
                    end
                end

                S_ADD: begin
                    if (pos_in_range) begin
                        r_pend <= 1'b1;
                        r_addr <= r_pos;
                        r_pos  <= r_pos + POS_W'(r_prime);
                    end else begin
                        // Walk finished: the last write lands this cycle
                        r_pend <= 1'b0;
                        if (r_second) begin
                            r_state <= S_DONE;
                        end else begin
                            r_second <= 1'b1;
                            r_pos    <= POS_W'(r_root_two);
                        end
                    end
                end

                S_FIND: begin
                    if (hit) begin
                        r_pend      <= 1'b0;
                        r_res_found <= 1'b1;
                        r_res_index <= r_addr[15:0];
                        r_res_value <= r_rdata;
                        r_state     <= S_DONE;
                    end else if (pos_in_range) begin
                        r_pend <= 1'b1;
                        r_addr <= r_pos;
                        r_pos  <= r_pos + POS_W'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // Hold until the output register is free
                    if (out_load) begin
                        r_out_found <= r_res_found;
                        r_out_index <= r_res_index;
                        r_out_value <= r_res_value;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.found = r_out_found;
    assign o_res.index = r_out_index;
    assign o_res.value = r_out_value;

endmodule

/* hdl/sas_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_checker: port-level checks of the sieve accumulate and scan block
// Watches the request, result and threshold ports and is bound to the top.
// ----------------------------------------------------------------------------
module sas_checker import sas_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_cfg_wr_en,
    input t_byte  i_cfg_wr_data,
    input logic   i_req_valid,
    input logic   i_req_ready,
    input logic   i_res_valid,
    input logic   i_res_ready,
    input logic   i_res_found,
    input t_index i_res_index,
    input t_byte  i_res_value
);

    logic       req_acc;
    logic       res_acc;
    logic [1:0] r_owed;
    t_byte      r_threshold;

    assign req_acc = i_req_valid && i_req_ready;
    assign res_acc = i_res_valid && i_res_ready;

    // Track requests whose result is still owed, and the live threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed      <= '0;
            r_threshold <= THRESHOLD_RESET;
        end else begin
            r_owed <= r_owed + 2'(req_acc) - 2'(res_acc);
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_found)
            && $stable(i_res_index) && $stable(i_res_value))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req_ready)
        else $error("request taken while another is in work");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> r_owed != 2'd0)
        else $error("result without a request");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_found |-> i_res_index == '0 && i_res_value == '0)
        else $error("result without candidate carries data");

    a_above_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_found |-> i_res_value > r_threshold)
        else $error("candidate not above threshold");

endmodule

bind sieve_accumulate_and_scan sas_checker u_sas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_found   (o_res.found),
    .i_res_index   (o_res.index),
    .i_res_value   (o_res.value)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sieve accumulate and scan block
// Drives clear, add, find and spare-code requests over the request channel and checks
// each result against a bit-accurate copy of the sieve counters held here, or against
// the result typed into the directed table that opens the run. Six random phases
// follow, each with its own threshold, with random gaps on the request side and
// random back-pressure on the result side, save one phase that runs flat out.
// ----------------------------------------------------------------------------
module tb_top;
    import sas_pkg::*;

    localparam int          STORE_DEPTH = 65536;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    localparam int          RANDOM_REQS = 1030;
    localparam int          PHASES      = 6;
    // Longest distance a random find is allowed to walk before its candidate
    localparam int unsigned SCAN_REACH  = 1024;
    // Spare operation code: no state change, empty result
    localparam t_op         OP_SPARE    = 2'd3;

    typedef struct packed {
        t_op    op;
        t_prime prime;
        t_prime root_one;
        t_prime root_two;
        logic   root_two_valid;
        t_byte  log_weight;
        t_index start_index;
    } t_request;

    typedef struct packed {
        logic   found;
        t_index index;
        t_byte  value;
    } t_result;

    typedef struct packed {
        t_request req;
        logic     fixed;    // result typed into the table, not predicted
        t_result  res;
    } t_table_row;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_wr_en;
    t_byte cfg_wr_data;

    sas_req_if req_if ();
    sas_res_if res_if ();

    sieve_accumulate_and_scan #(
        .SIEVE_BYTES (STORE_DEPTH)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_if),
        .o_res         (res_if)
    );

    // Local copy of the counter store and the threshold register
    t_byte       sieve_model [STORE_DEPTH];
    t_byte       threshold_model = THRESHOLD_RESET;
    // Results owed by the block, oldest first
    t_result     scan_results_due [$];
    t_table_row  directed_rows [$];
    int          errors = 0;
    int unsigned cycle_count = 0;
    bit          idling_on = 1'b1;
    int          clears_left = 3;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: give up once the run is far beyond any correct length
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Add the weight at first, first+stride, ... below the sieve size
    function automatic void stride_add(input int unsigned first, input int unsigned stride,
                                       input t_byte weight);
        for (int unsigned p = first; p < STORE_DEPTH; p += stride)
            sieve_model[p] = sieve_model[p] + weight;
    endfunction

    // Find the first counter above the threshold in [from, upto)
    function automatic void scan_for_candidate(input int unsigned from, input int unsigned upto,
                                               output bit hit, output int unsigned pos);
        hit = 1'b0;
        pos = 0;
        for (int unsigned p = from; p < upto && !hit; p++) begin
            if (sieve_model[p] > threshold_model) begin
                hit = 1'b1;
                pos = p;
            end
        end
    endfunction

    // Apply one request to the local store and return the result it owes
    function automatic t_result predict_sieve_op(input t_request rq);
        t_result     res;
        bit          hit;
        int unsigned pos;
        res = '0;
        case (rq.op)
            OP_CLEAR: begin
                foreach (sieve_model[i]) sieve_model[i] = '0;
            end
            OP_ADD: begin
                // An invalid second root or a zero stride leaves the store alone
                if (rq.root_two_valid && rq.prime != '0) begin
                    stride_add(32'(rq.root_one), 32'(rq.prime), rq.log_weight);
                    stride_add(32'(rq.root_two), 32'(rq.prime), rq.log_weight);
                end
            end
            OP_FIND: begin
                scan_for_candidate(32'(rq.start_index), STORE_DEPTH, hit, pos);
                if (hit) begin
                    res.found = 1'b1;
                    res.index = pos[15:0];
                    res.value = sieve_model[pos];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Channel handling
    // ------------------------------------------------------------------------

    // Gap length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one request, hold it until taken, then log what it owes.
    // Valid stays high into the next request when no gap is drawn.
    task automatic send_request(input t_request rq, input bit fixed, input t_result fixed_res);
        int      gap;
        t_result predicted;
        gap = idling_on ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.operation      <= rq.op;
        req_if.prime          <= rq.prime;
        req_if.root_one       <= rq.root_one;
        req_if.root_two       <= rq.root_two;
        req_if.root_two_valid <= rq.root_two_valid;
        req_if.log_weight     <= rq.log_weight;
        req_if.start_index    <= rq.start_index;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        // Keep the predictor in step even where the result is typed in
        predicted = predict_sieve_op(rq);
        scan_results_due.push_back(fixed ? fixed_res : predicted);
    endtask

    // Drop valid and hold off until every owed result has been collected
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (scan_results_due.size() != 0);
    endtask

    task automatic add_row(input t_op op, input int unsigned prime, input int unsigned r1,
                           input int unsigned r2, input bit r2_valid, input int unsigned weight,
                           input int unsigned start, input bit fixed, input bit found,
                           input int unsigned index, input int unsigned value);
        t_table_row row;
        row.req.op             = op;
        row.req.prime          = t_prime'(prime);
        row.req.root_one       = t_prime'(r1);
        row.req.root_two       = t_prime'(r2);
        row.req.root_two_valid = r2_valid;
        row.req.log_weight     = t_byte'(weight);
        row.req.start_index    = t_index'(start);
        row.fixed              = fixed;
        row.res.found          = found;
        row.res.index          = t_index'(index);
        row.res.value          = t_byte'(value);
        directed_rows.push_back(row);
    endtask

    // Result side back-pressure: random stalls while idling is enabled
    initial begin : result_backpressure
        int hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (idling_on && $urandom_range(0, 2) == 0)
                hold = pick_gap();
            res_if.ready <= (hold == 0);
        end
    end

    // Compare each collected result, field by field, with the oldest one owed
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (scan_results_due.size() == 0) begin
                $display("%0t: extra result: expected none, actual found %0b index %0d value %0d",
                         $time, res_if.found, res_if.index, res_if.value);
                errors++;
            end else begin
                want = scan_results_due.pop_front();
                if (res_if.found !== want.found) begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, want.found, res_if.found);
                    errors++;
                end
                if (res_if.index !== want.index) begin
                    $display("%0t: index mismatch: expected %0d, actual %0d",
                             $time, want.index, res_if.index);
                    errors++;
                end
                if (res_if.value !== want.value) begin
                    $display("%0t: value mismatch: expected %0d, actual %0d",
                             $time, want.value, res_if.value);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_request    rq;
        t_byte       level;
        int          roll;
        int          pick;
        int          phase;
        int          n;
        int          tries;
        bit          found_start;
        bit          hit;
        int unsigned from;
        int unsigned pos;
        int unsigned upto;

        foreach (sieve_model[i]) sieve_model[i] = '0;
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= '0;
        req_if.valid          <= 1'b0;
        req_if.operation      <= OP_CLEAR;
        req_if.prime          <= '0;
        req_if.root_one       <= '0;
        req_if.root_two       <= '0;
        req_if.root_two_valid <= 1'b0;
        req_if.log_weight     <= '0;
        req_if.start_index    <= '0;

        // Directed table, run at the reset threshold on a freshly cleared store.
        //       op        prime      root_one   root_two   v  wt   start fix f  index  val
        // Nothing above the threshold straight after reset
        add_row(OP_FIND,  0,         0,         0,         0, 0,   0,     1,  0, 0,     0);
        // Equal roots add the weight twice: 40 at 5, 1005, ...
        add_row(OP_ADD,   1000,      5,         5,         1, 20,  0,     1,  0, 0,     0);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   0,     1,  1, 5,     40);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   6,     1,  1, 1005,  40);
        // Zero stride and invalid second root both leave the store alone
        add_row(OP_ADD,   0,         0,         0,         1, 255, 0,     1,  0, 0,     0);
        add_row(OP_ADD,   3,         0,         1,         0, 200, 0,     1,  0, 0,     0);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   0,     1,  1, 5,     40);
        // Unit stride near the top, weight wraps to 254 where both roots meet
        add_row(OP_ADD,   1,         65530,     65534,     1, 255, 0,     1,  0, 0,     0);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   65530, 1,  1, 65530, 255);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   65535, 1,  1, 65535, 254);
        // Roots beyond the sieve hit nothing
        add_row(OP_ADD,   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE, 1, 255, 0,  1,  0, 0,     0);
        // Root above the prime, second root on the last entry
        add_row(OP_ADD,   100,       150,       65535,     1, 1,   0,     0,  0, 0,     0);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   65535, 0,  0, 0,     0);
        // Spare code with every field at its top: empty result, no change
        add_row(OP_SPARE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 255, 65535, 1, 0, 0,   0);
        // Zero weight
        add_row(OP_ADD,   300,       7,         8,         1, 0,   0,     0,  0, 0,     0);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   60000, 0,  0, 0,     0);
        // Clear, then an empty tail scan
        add_row(OP_CLEAR, 0,         0,         0,         0, 0,   0,     1,  0, 0,     0);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   60000, 1,  0, 0,     0);
        // Threshold boundary: 39 qualifies, 38 does not
        add_row(OP_ADD,   4096,      4095,      0,         1, 39,  0,     1,  0, 0,     0);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   0,     1,  1, 0,     39);
        add_row(OP_ADD,   4096,      0,         24'hFFFFFF, 1, 255, 0,    1,  0, 0,     0);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   0,     1,  1, 4095,  39);
        add_row(OP_FIND,  0,         0,         0,         0, 0,   65535, 1,  1, 65535, 39);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the table; the clearing pass after reset simply holds off
        // the first request until ready rises
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].res);

        for (phase = 0; phase < PHASES; phase++) begin
            // Write the threshold only once the block has gone quiet
            drain_results();
            repeat (4) @(posedge clk);
            case (phase)
                0:       level = 8'd0;
                1:       level = 8'd255;
                3:       level = 8'd1;
                5:       level = THRESHOLD_RESET;
                default: level = t_byte'($urandom_range(2, 254));
            endcase
            cfg_wr_en       <= 1'b1;
            cfg_wr_data     <= level;
            threshold_model = level;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            // One phase runs flat out on both sides
            idling_on = (phase != 3);

            for (n = 0; n < RANDOM_REQS / PHASES; n++) begin
                // Now and then hold the sender until every result is in
                if ($urandom_range(0, 99) == 0)
                    drain_results();

                rq.op             = OP_FIND;
                rq.prime          = t_prime'($urandom);
                rq.root_one       = t_prime'($urandom);
                rq.root_two       = t_prime'($urandom);
                rq.root_two_valid = 1'($urandom_range(0, 1));
                rq.log_weight     = t_byte'($urandom);
                rq.start_index    = t_index'($urandom);
                roll = $urandom_range(0, 999);

                if (roll < 5 && clears_left > 0) begin
                    // Rare clear: a full pass over the store
                    rq.op = OP_CLEAR;
                    clears_left--;
                end else if (roll < 470) begin
                    // Well-formed add: roots below the prime, strides that land
                    rq.op = OP_ADD;
                    pick  = $urandom_range(0, 9);
                    if (pick < 7)
                        rq.prime = t_prime'($urandom_range(256, 4096));
                    else if (pick < 9)
                        rq.prime = t_prime'($urandom_range(4097, 65535));
                    else
                        rq.prime = t_prime'($urandom_range(65536, 24'hFFFFFF));
                    rq.root_one = t_prime'($urandom_range(0, 32'(rq.prime) - 1));
                    if ($urandom_range(0, 9) == 0)
                        rq.root_two = rq.root_one;
                    else
                        rq.root_two = t_prime'($urandom_range(0, 32'(rq.prime) - 1));
                    rq.root_two_valid = ($urandom_range(0, 9) != 0);
                    case ($urandom_range(0, 4))
                        0:       rq.log_weight = 8'd0;
                        1:       rq.log_weight = 8'd255;
                        default: rq.log_weight = t_byte'($urandom_range(0, 255));
                    endcase
                end else if (roll < 520) begin
                    // Noise: spare code, or an add with roots anywhere
                    rq.op = ($urandom_range(0, 1) == 0) ? OP_SPARE : OP_ADD;
                    if ($urandom_range(0, 7) == 0)
                        rq.prime = '0;
                    else
                        rq.prime = t_prime'($urandom_range(256, 24'hFFFFFF));
                end else begin
                    // Find: aim near a candidate so the scan stays short,
                    // else start close enough to the top to run off the end
                    found_start = 1'b0;
                    from        = 0;
                    for (tries = 0; tries < 8 && !found_start; tries++) begin
                        from = $urandom_range(0, STORE_DEPTH - 1);
                        upto = from + SCAN_REACH + 1;
                        if (upto > STORE_DEPTH) upto = STORE_DEPTH;
                        scan_for_candidate(from, upto, hit, pos);
                        found_start = hit;
                    end
                    if (!found_start)
                        from = STORE_DEPTH - 1 - $urandom_range(0, 700);
                    rq.start_index = t_index'(from);
                end

                send_request(rq, 1'b0, '0);
            end
        end

        // Collect the last results, then linger to catch anything extra
        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
